>>> rtl/core/glpb_pkg.sv
package glpb_pkg;

    // Field widths fixed by the pixel and palette formats.
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned COORD_W  = 8;
    localparam int unsigned LWIDTH_W = 9;
    localparam int unsigned PIXX_W   = 10;
    localparam int unsigned PIXY_W   = 8;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSP_ON   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSP_IDX  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RESTORE_BG  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BG_IDX      = 3'd5;

    // Request kind carried in tuser.
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_DRAW      = 1'b1;

    // Input request payload, last declared field in the lowest bits.
    localparam int unsigned IN_BITS   = INDEX_W + COLOR_W + 4 * COORD_W + LWIDTH_W;
    localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [IN_DATA_W-IN_BITS-1:0] pad;
        logic [LWIDTH_W-1:0]          line_width;
        logic [COORD_W-1:0]           frame_row;
        logic [COORD_W-1:0]           frame_top;
        logic [COORD_W-1:0]           frame_left;
        logic [COORD_W-1:0]           column;
        logic [COLOR_W-1:0]           color_word;
        logic [INDEX_W-1:0]           index_value;
    } t_req_in;

    // Output request payload, last declared field in the lowest bits.
    localparam int unsigned OUT_BITS   = PIXX_W + PIXY_W + COLOR_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [OUT_DATA_W-OUT_BITS-1:0] pad;
        logic [COLOR_W-1:0]             pixel_color;
        logic [PIXY_W-1:0]              pixel_y;
        logic [PIXX_W-1:0]              pixel_x;
    } t_req_out;

endpackage

>>> rtl/core/gif_line_palette_blit.sv
// Palette expander for GIF lines: palette-write requests fill a colour store held in one
// synchronous memory, and draw requests look up that store and emit screen x, y and an
// RGB565 colour, after dropping lines below the screen, columns past the clipped width
// and transparent pixels (or swapping in the background index in restore mode). One
// request is taken every clock while the output register is empty or being drained; a
// surviving pixel appears in the cycle after it is taken, its colour held in the registered
// read port of the palette memory, which feeds the output directly. A palette write is
// visible to a draw taken in the very next cycle.
module gif_line_palette_blit #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 240,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input request stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: index_value, color_word, column, frame_left, frame_top,
    // frame_row, line_width, zero padding.
    input  logic [glpb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: func (palette write or draw).
    input  logic                                s_axis_tuser,
    // Output pixel stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: pixel_x, pixel_y, pixel_color, zero padding.
    output logic [glpb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [glpb_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [glpb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CMP_W  = 12;

    // Configuration registers.
    logic [glpb_pkg::COORD_W-1:0] r_offset_x;
    logic [glpb_pkg::COORD_W-1:0] r_offset_y;
    logic                         r_transp_on;
    logic [glpb_pkg::INDEX_W-1:0] r_transp_idx;
    logic                         r_restore_bg;
    logic [glpb_pkg::INDEX_W-1:0] r_bg_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_transp_on  <= 1'b0;
            r_transp_idx <= '0;
            r_restore_bg <= 1'b0;
            r_bg_idx     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                glpb_pkg::REG_OFFSET_X:   r_offset_x   <= i_cfg_data;
                glpb_pkg::REG_OFFSET_Y:   r_offset_y   <= i_cfg_data;
                glpb_pkg::REG_TRANSP_ON:  r_transp_on  <= i_cfg_data[0];
                glpb_pkg::REG_TRANSP_IDX: r_transp_idx <= i_cfg_data;
                glpb_pkg::REG_RESTORE_BG: r_restore_bg <= i_cfg_data[0];
                glpb_pkg::REG_BG_IDX:     r_bg_idx     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the incoming request.
    glpb_pkg::t_req_in w_req;
    assign w_req = s_axis_tdata;

    logic r_out_valid;
    logic w_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Screen placement and clipping of the draw request.
    logic [glpb_pkg::PIXX_W-1:0] w_pix_x;
    logic [glpb_pkg::PIXX_W-1:0] w_pix_y_full;
    logic [CMP_W-1:0]            w_left_col;
    logic                        w_on_screen;
    logic                        w_is_transp;
    logic                        w_skip;
    logic                        w_draw_ok;
    logic [glpb_pkg::INDEX_W-1:0] w_chosen;
    logic                        w_in_range;

    always_comb begin
        w_pix_x      = glpb_pkg::PIXX_W'(r_offset_x) + glpb_pkg::PIXX_W'(w_req.frame_left)
                     + glpb_pkg::PIXX_W'(w_req.column);
        w_pix_y_full = glpb_pkg::PIXX_W'(r_offset_y) + glpb_pkg::PIXX_W'(w_req.frame_top)
                     + glpb_pkg::PIXX_W'(w_req.frame_row);
        w_left_col   = CMP_W'(w_req.frame_left) + CMP_W'(w_req.column);
        // The clipped width is min(line_width, screen width - left), so the column must
        // lie below both bounds; this also drops an empty line.
        w_on_screen  = (CMP_W'(w_pix_y_full) < CMP_W'(SCREEN_HEIGHT))
                     && (CMP_W'(w_req.frame_left) < CMP_W'(SCREEN_WIDTH))
                     && (glpb_pkg::LWIDTH_W'(w_req.column) < w_req.line_width)
                     && (w_left_col < CMP_W'(SCREEN_WIDTH));
        w_is_transp  = (w_req.index_value == r_transp_idx);
        w_skip       = r_transp_on && !r_restore_bg && w_is_transp;
        w_draw_ok    = w_on_screen && !w_skip;
        w_chosen     = (r_restore_bg && w_is_transp) ? r_bg_idx : w_req.index_value;
        w_in_range   = (CMP_W'(w_chosen) < CMP_W'(PALETTE_DEPTH));
    end

    // Palette memory: written by palette-write requests, read when a draw is taken.
    logic [glpb_pkg::COLOR_W-1:0] r_palette [PALETTE_DEPTH];
    logic [glpb_pkg::COLOR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == glpb_pkg::FUNC_PAL_WRITE
                && CMP_W'(w_req.index_value) < CMP_W'(PALETTE_DEPTH)) begin
            r_palette[w_req.index_value[ADDR_W-1:0]] <= w_req.color_word;
        end
        if (w_accept && s_axis_tuser == glpb_pkg::FUNC_DRAW) begin
            r_rd_data <= r_palette[w_chosen[ADDR_W-1:0]];
        end
    end

    // Output register beside the memory read data.
    logic [glpb_pkg::PIXX_W-1:0] r_pix_x;
    logic [glpb_pkg::PIXY_W-1:0] r_pix_y;
    logic                        r_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= w_accept && (s_axis_tuser == glpb_pkg::FUNC_DRAW) && w_draw_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser == glpb_pkg::FUNC_DRAW) begin
            r_pix_x    <= w_pix_x;
            r_pix_y    <= w_pix_y_full[glpb_pkg::PIXY_W-1:0];
            r_in_range <= w_in_range;
        end
    end

    // Pack the result; an index beyond the palette reads as zero.
    glpb_pkg::t_req_out w_out;

    always_comb begin
        w_out             = '0;
        w_out.pixel_x     = r_pix_x;
        w_out.pixel_y     = r_pix_y;
        w_out.pixel_color = r_in_range ? r_rd_data : '0;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = w_out;

endmodule
